/* sv/wma_pkg.sv */
// Shared types and constants for the windowed moving average core.
// No dependencies; used by windowed_moving_average_core.
package wma_pkg;

  // Width of the window length register and of the fill count
  localparam int CNT_BITS = 8;

  // Window length after reset
  localparam logic [CNT_BITS-1:0] WINDOW_RESET = 8'd70;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_INSERT,
    S_ABS,
    S_DIV,
    S_FIX,
    S_DONE
  } state_t;

endpackage

/* sv/wma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/windowed_moving_average_core.sv */
// Windowed moving average: each sample enters a ring of the most recent samples,
// the oldest is evicted once the window is full, and one item comes out per sample.
// Depends on wma_pkg and wma_ram.

// Each accepted sample (signed Q8.8) joins a window of at most window_length
// samples (clamped to 1..MAX_WINDOW); a full window drops its oldest sample
// first. Every sample yields one item: the mean of the held samples, truncated
// toward zero, and the number held. A write on the configuration channel sets
// window_length and empties the window. Each accepted sample passes through an
// evict step when the window is full, then insert, absolute value, the
// bit-serial restoring divider (SUM_BITS = SAMPLE_BITS + clog2(MAX_WINDOW) + 1
// quotient bits, one quotient bit per cycle on the same adder that maintains
// the running sum), sign fix and done; the divider takes most of the time. The
// block takes no new sample while it works; a finished item waits in the output
// register while the next sample is accepted, and a new result waits until that
// register is free. Samples live in a MAX_WINDOW-entry RAM.
module windowed_moving_average_core #(
  parameter int MAX_WINDOW  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wma_pkg::CNT_BITS-1:0]  cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic [wma_pkg::CNT_BITS-1:0]  fill_count
);

  localparam int PTR_BITS  = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS + 1;
  localparam int DCNT_BITS = $clog2(SUM_BITS);
  localparam int CNT_BITS  = wma_pkg::CNT_BITS;

  wma_pkg::state_t state, state_next;

  logic [CNT_BITS-1:0]    window_length;
  logic [CNT_BITS-1:0]    len_eff;
  logic [CNT_BITS-1:0]    held;
  logic [PTR_BITS-1:0]    wp;
  logic [PTR_BITS-1:0]    oldest;
  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] sample_reg;
  logic                   evict;

  // divider registers
  logic [SUM_BITS-1:0]    quo;
  logic [CNT_BITS-1:0]    rem;
  logic                   neg;
  logic [DCNT_BITS-1:0]   dcnt;
  logic                   div_last;
  logic [CNT_BITS:0]      shifted;

  // shared adder
  logic [SUM_BITS-1:0]    alu_a;
  logic [SUM_BITS-1:0]    alu_b;
  logic                   alu_sub;
  logic [SUM_BITS-1:0]    alu_y;

  // ring memory
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  int old_i;

  logic in_fire;
  logic cfg_fire;
  logic out_free;

  assign cfg_ready = (state == wma_pkg::S_IDLE);
  assign in_ready  = (state == wma_pkg::S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_BITS'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      len_eff = CNT_BITS'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
  end

  // Locate the oldest held sample
  always_comb begin
    old_i = int'(wp) - int'(held);
    if (old_i < 0) begin
      old_i = old_i + MAX_WINDOW;
    end
    oldest = PTR_BITS'(old_i);
  end

  assign shifted  = {rem, quo[SUM_BITS-1]};
  assign div_last = (dcnt == DCNT_BITS'(SUM_BITS - 1));

  wma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (sample_reg),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wma_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = (held >= len_eff) ? wma_pkg::S_EVICT : wma_pkg::S_INSERT;
        end
      end
      wma_pkg::S_EVICT:  state_next = wma_pkg::S_INSERT;
      wma_pkg::S_INSERT: state_next = wma_pkg::S_ABS;
      wma_pkg::S_ABS:    state_next = wma_pkg::S_DIV;
      wma_pkg::S_DIV: begin
        if (div_last) begin
          state_next = wma_pkg::S_FIX;
        end
      end
      wma_pkg::S_FIX:    state_next = wma_pkg::S_DONE;
      wma_pkg::S_DONE: begin
        if (out_free) begin
          state_next = wma_pkg::S_IDLE;
        end
      end
      default:           state_next = wma_pkg::S_IDLE;
    endcase
  end

  // Steer the shared adder and the memory write
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    ram_we  = 1'b0;
    case (state)
      wma_pkg::S_EVICT: begin
        alu_a   = sum;
        alu_b   = {{(SUM_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
        alu_sub = 1'b1;
      end
      wma_pkg::S_INSERT: begin
        alu_a   = sum;
        alu_b   = {{(SUM_BITS-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
        ram_we  = 1'b1;
      end
      wma_pkg::S_ABS: begin
        alu_b   = sum;
        alu_sub = sum[SUM_BITS-1];
      end
      wma_pkg::S_DIV: begin
        alu_a   = {{(SUM_BITS-CNT_BITS-1){1'b0}}, shifted};
        alu_b   = {{(SUM_BITS-CNT_BITS){1'b0}}, held};
        alu_sub = 1'b1;
      end
      wma_pkg::S_FIX: begin
        alu_b   = quo;
        alu_sub = neg;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wma_pkg::S_IDLE;
      window_length <= wma_pkg::WINDOW_RESET;
      held          <= '0;
      wp            <= '0;
      sum           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // Load the output register when a result is done, drop it once taken
      if (state == wma_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        wma_pkg::S_IDLE: begin
          if (cfg_fire) begin
            window_length <= cfg_data;
            held          <= '0;
            wp            <= '0;
            sum           <= '0;
          end
        end
        wma_pkg::S_EVICT: begin
          sum  <= alu_y;
          held <= held - 1'b1;
        end
        wma_pkg::S_INSERT: begin
          sum  <= alu_y;
          held <= held + 1'b1;
          wp   <= (int'(wp) == MAX_WINDOW - 1) ? '0 : wp + 1'b1;
        end
        default: begin
          held <= held;
        end
      endcase
    end
  end

  // Hold the sample, run the divider, load the result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_reg <= sample;
      evict      <= (held >= len_eff);
    end
    case (state)
      wma_pkg::S_ABS: begin
        quo  <= alu_y;
        rem  <= '0;
        neg  <= sum[SUM_BITS-1];
        dcnt <= '0;
      end
      wma_pkg::S_DIV: begin
        dcnt <= dcnt + 1'b1;
        if (!alu_y[SUM_BITS-1]) begin
          rem <= alu_y[CNT_BITS-1:0];
          quo <= {quo[SUM_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[CNT_BITS-1:0];
          quo <= {quo[SUM_BITS-2:0], 1'b0};
        end
      end
      wma_pkg::S_FIX: begin
        quo <= alu_y;
      end
      wma_pkg::S_DONE: begin
        if (out_free) begin
          average    <= quo[SAMPLE_BITS-1:0];
          fill_count <= held;
        end
      end
      default: begin
        dcnt <= dcnt;
      end
    endcase
  end

  // A sample accepted into a full window always goes through eviction
  a_evict_path: assert property (@(posedge clk) disable iff (rst)
    (state == wma_pkg::S_INSERT && $past(state) == wma_pkg::S_IDLE) |-> !evict)
    else $error("full window skipped eviction");

  // Window never holds more samples than its length
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= len_eff)
    else $error("window overfilled");

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == wma_pkg::S_DIV) |-> (rem < held))
    else $error("divider remainder out of range");

  // A delivered item never reports an empty window
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count != '0))
    else $error("item with empty window");

endmodule
